// File: rtl/kscd_pkg.sv
// kscd_pkg: shared types and constants for the knob smoothing change detector
// no dependencies; imported by the interfaces and every rtl module

package kscd_pkg;

    // payload widths fixed by the channel fields
    localparam int SAMPLE_W   = 12;
    localparam int CHAN_W     = 8;
    localparam int FRAC_W     = 8;
    localparam int FILT_W     = SAMPLE_W + FRAC_W;
    localparam int GAIN_W     = 9;
    localparam int THRESH_W   = 20;
    localparam int SUM_W      = SAMPLE_W + 2;

    // configuration registers
    localparam int APB_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;
    localparam logic [GAIN_W-1:0]   GAIN_ONE     = 9'd256;
    localparam logic [GAIN_W-1:0]   GAIN_RESET   = 9'd51;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 20'd15724;

    typedef enum logic {
        REG_GAIN   = 1'b0,
        REG_THRESH = 1'b1
    } t_reg_idx;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef enum logic {
        REQ_SAMPLE  = 1'b0,
        REQ_CONSUME = 1'b1
    } t_req;

    typedef struct packed {
        logic [GAIN_W-1:0]   gain;
        logic [THRESH_W-1:0] threshold;
    } t_cfg;

    // classified request as it sits in the queue
    typedef struct packed {
        t_req                req_type;
        logic                in_range;
        logic [CHAN_W-1:0]   channel;
        logic [SAMPLE_W-1:0] average;
    } t_item;

    // per channel value store entry
    typedef struct packed {
        logic [SAMPLE_W-1:0] raw;
        logic [FILT_W-1:0]   filt;
        logic [FILT_W-1:0]   pend;
    } t_entry;

    typedef struct packed {
        logic [SAMPLE_W-1:0] raw_average;
        logic [FILT_W-1:0]   filtered_value;
        logic                change_flag;
        logic [FILT_W-1:0]   change_value;
    } t_result;

endpackage

// File: rtl/kscd_if.sv
// kscd_req_if and kscd_rsp_if: valid/ready channels for requests and results
// depends on kscd_pkg for field widths

interface kscd_req_if import kscd_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [0:0]          req_type;
    logic [CHAN_W-1:0]   channel;
    logic [SAMPLE_W-1:0] sample_a;
    logic [SAMPLE_W-1:0] sample_b;
    logic [SAMPLE_W-1:0] sample_c;
    logic [SAMPLE_W-1:0] sample_d;

    modport source (
        output valid, req_type, channel, sample_a, sample_b, sample_c, sample_d,
        input  ready
    );
    modport sink (
        input  valid, req_type, channel, sample_a, sample_b, sample_c, sample_d,
        output ready
    );
endinterface

interface kscd_rsp_if import kscd_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] raw_average;
    logic [FILT_W-1:0]   filtered_value;
    logic                change_flag;
    logic [FILT_W-1:0]   change_value;

    modport source (
        output valid, raw_average, filtered_value, change_flag, change_value,
        input  ready
    );
    modport sink (
        input  valid, raw_average, filtered_value, change_flag, change_value,
        output ready
    );
endinterface

// File: rtl/kscd_front.sv
// kscd_front: accepts requests, averages the samples and checks the channel range
// depends on kscd_pkg and kscd_req_if

module kscd_front import kscd_pkg::*; #(
    parameter int CHANNELS = 8
) (
    kscd_req_if.sink i_req,
    input  logic     i_full,
    output logic     o_push,
    output t_item    o_item
);

    logic [SUM_W-1:0] sum;

    assign i_req.ready = !i_full;
    assign o_push      = i_req.valid && !i_full;

    always_comb begin
        sum = SUM_W'(i_req.sample_a) + SUM_W'(i_req.sample_b)
            + SUM_W'(i_req.sample_c) + SUM_W'(i_req.sample_d);
        o_item.req_type = t_req'(i_req.req_type);
        o_item.in_range = ({1'b0, i_req.channel} < (CHAN_W+1)'(CHANNELS));
        o_item.channel  = i_req.channel;
        // truncated divide by four
        o_item.average  = sum[SUM_W-1:2];
    end

endmodule

// File: rtl/kscd_queue.sv
// kscd_queue: short fifo of classified requests between front and back
// depends on kscd_pkg

module kscd_queue import kscd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_pop
);

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QPTR_W:0]   r_count;

    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            priority if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: rtl/kscd_back.sv
// kscd_back: per channel store, filter update, change latch and result register
// depends on kscd_pkg and kscd_rsp_if

module kscd_back import kscd_pkg::*; #(
    parameter int CHANNELS = 8
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_q_valid,
    input  t_item i_q_item,
    output logic  o_q_pop,
    kscd_rsp_if.source o_rsp
);

    localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PROD_W = FILT_W + 1 + GAIN_W + 1;
    localparam int STEP_W = PROD_W - FRAC_W;

    t_entry            r_mem [CHANNELS];
    t_entry            r_rd;
    logic [CHANNELS-1:0] r_primed;
    logic [CHANNELS-1:0] r_pflag;
    t_item             r_s2;
    logic              r_s2_valid;
    t_result           r_out;
    logic              r_out_valid;

    logic              out_free;
    logic              s2_go;
    logic              s1_adv;
    logic              rd_en;
    logic              wr_en;
    logic [IDX_W-1:0]  s1_idx;
    logic [IDX_W-1:0]  s2_idx;
    logic              primed_rd;
    logic              pflag_rd;
    t_entry            cur;
    logic [FILT_W-1:0] target;
    logic [GAIN_W-1:0] gain_sat;
    logic signed [FILT_W:0]   diff;
    logic signed [PROD_W-1:0] prod;
    logic signed [STEP_W-1:0] sum_f;
    logic [FILT_W-1:0] new_f;
    logic [FILT_W-1:0] gap;
    logic              hit;
    t_entry            n_entry;
    logic              n_primed;
    logic              n_pflag;
    t_result           n_result;

    assign out_free = !r_out_valid || o_rsp.ready;
    assign s2_go    = r_s2_valid && out_free;
    assign s1_adv   = !r_s2_valid || s2_go;
    assign o_q_pop  = i_q_valid && s1_adv;
    assign rd_en    = o_q_pop && i_q_item.in_range;
    assign s1_idx   = i_q_item.channel[IDX_W-1:0];
    assign s2_idx   = r_s2.channel[IDX_W-1:0];
    assign wr_en    = s2_go && r_s2.in_range && (r_s2.req_type == REQ_SAMPLE);

    // filter update and change decision
    always_comb begin
        primed_rd = r_s2.in_range ? r_primed[s2_idx] : 1'b0;
        pflag_rd  = r_s2.in_range ? r_pflag[s2_idx] : 1'b0;
        cur       = primed_rd ? r_rd : '0;
        target    = {r_s2.average, {FRAC_W{1'b0}}};
        gain_sat  = (i_cfg.gain > GAIN_ONE) ? GAIN_ONE : i_cfg.gain;
        diff      = $signed({1'b0, target}) - $signed({1'b0, cur.filt});
        prod      = PROD_W'(diff) * $signed(PROD_W'({1'b0, gain_sat}));
        // arithmetic shift gives the floor; result stays between old value and target
        sum_f     = $signed(STEP_W'({1'b0, cur.filt})) + prod[PROD_W-1:FRAC_W];
        new_f     = sum_f[FILT_W-1:0];
        gap       = (new_f >= cur.pend) ? (new_f - cur.pend) : (cur.pend - new_f);
        hit       = (gap >= i_cfg.threshold);

        n_entry   = cur;
        n_primed  = primed_rd;
        n_pflag   = pflag_rd;
        n_result  = '0;
        if (r_s2.in_range) begin
            unique case (r_s2.req_type)
                REQ_SAMPLE: begin
                    n_primed    = 1'b1;
                    n_entry.raw = r_s2.average;
                    if (!primed_rd) begin
                        // first sample primes filter and pending value
                        n_entry.filt = target;
                        n_entry.pend = target;
                    end else begin
                        n_entry.filt = new_f;
                        if (hit) begin
                            n_entry.pend          = new_f;
                            n_pflag               = 1'b1;
                            n_result.change_flag  = 1'b1;
                            n_result.change_value = new_f;
                        end
                    end
                    n_result.raw_average    = n_entry.raw;
                    n_result.filtered_value = n_entry.filt;
                end
                REQ_CONSUME: begin
                    n_pflag                 = 1'b0;
                    n_result.raw_average    = cur.raw;
                    n_result.filtered_value = cur.filt;
                    n_result.change_flag    = pflag_rd;
                    n_result.change_value   = pflag_rd ? cur.pend : '0;
                end
                default: begin
                    n_result = '0;
                end
            endcase
        end
    end

    // value store, write-first read so a same-channel follower sees the update
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[s2_idx] <= n_entry;
        end
        if (rd_en) begin
            r_rd <= (wr_en && (s2_idx == s1_idx)) ? n_entry : r_mem[s1_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed <= '0;
            r_pflag  <= '0;
        end else if (s2_go && r_s2.in_range) begin
            r_primed[s2_idx] <= n_primed;
            r_pflag[s2_idx]  <= n_pflag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_s2_valid <= i_q_valid;
            end
            if (out_free) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_s2 <= i_q_item;
        end
        if (s2_go) begin
            r_out <= n_result;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.raw_average    = r_out.raw_average;
    assign o_rsp.filtered_value = r_out.filtered_value;
    assign o_rsp.change_flag    = r_out.change_flag;
    assign o_rsp.change_value   = r_out.change_value;

endmodule

// File: rtl/knob_smoothing_change_detector_top.sv
// knob_smoothing_change_detector_top: top level with apb registers, front, queue, back
// depends on kscd_pkg, kscd_if, kscd_front, kscd_queue and kscd_back
//
//   channel   direction  handshake           payload
//   i_req     in         valid/ready         req_type, channel, sample_a..sample_d
//   o_rsp     out        valid/ready         raw_average, filtered_value,
//                                            change_flag, change_value
//   apb       in/out     psel/penable/pready gain at 0x0, threshold at 0x4
//
// one transaction per cycle sustained unless o_rsp stalls; o_rsp.valid rises once the
// item has passed the queue slot written at the accepting edge, the store read and the
// result register; the rate is set by the read-modify-write of the per channel store,
// with a write-first bypass so the same channel may repeat every cycle
// reset is synchronous and clears the primed and pending flags at once, no sweep
// o_rsp stalls back up into the four deep queue; i_req.ready drops only when it fills

module knob_smoothing_change_detector_top import kscd_pkg::*; #(
    parameter int CHANNELS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    kscd_req_if.sink              i_req,
    kscd_rsp_if.source            o_rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg  r_cfg;
    logic  cfg_wr;
    t_reg_idx reg_idx;

    logic  push;
    t_item push_item;
    logic  q_full;
    logic  q_valid;
    t_item q_item;
    logic  q_pop;

    // configuration registers, word aligned, low address bits ignored
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain      <= GAIN_RESET;
            r_cfg.threshold <= THRESH_RESET;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_GAIN:   r_cfg.gain      <= pwdata[GAIN_W-1:0];
                REG_THRESH: r_cfg.threshold <= pwdata[THRESH_W-1:0];
                default:    r_cfg           <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_GAIN:   prdata = APB_DATA_W'(r_cfg.gain);
            REG_THRESH: prdata = APB_DATA_W'(r_cfg.threshold);
            default:    prdata = '0;
        endcase
    end

    // front: accept and classify
    kscd_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .i_req  (i_req),
        .i_full (q_full),
        .o_push (push),
        .o_item (push_item)
    );

    // decoupling queue
    kscd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (q_pop)
    );

    // back: store access, filter, change latch, result register
    kscd_back #(
        .CHANNELS (CHANNELS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_rsp     (o_rsp)
    );

endmodule

// File: bench/kscd_knob_checker.sv
// kscd_knob_checker: watches request, result and apb traffic, predicts and compares
// depends on kscd_pkg and the kscd_req_if / kscd_rsp_if interfaces
module kscd_knob_checker import kscd_pkg::*; #(
    parameter int CHANNELS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    kscd_req_if                   i_req_mon,
    kscd_rsp_if                   i_rsp_mon,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic                  i_pready,
    input  logic [CFG_ADDR_W-1:0] i_paddr,
    input  logic [APB_DATA_W-1:0] i_pwdata,
    output int                    o_mismatches,
    output int                    o_in_flight
);
    timeunit 1ns;
    timeprecision 1ps;

    // per channel knob state
    logic [SAMPLE_W-1:0] avg_mem   [CHANNELS];
    logic [FILT_W-1:0]   filt_mem  [CHANNELS];
    logic [FILT_W-1:0]   held_mem  [CHANNELS];
    logic                held_flag [CHANNELS];
    logic                primed    [CHANNELS];

    logic [GAIN_W-1:0]   gain_reg;
    logic [THRESH_W-1:0] thresh_reg;

    t_result expected_results [$];
    int      mismatch_count;

    // one request against the knob state, returns the result it should give
    function automatic t_result knob_update(t_req kind, logic [CHAN_W-1:0] ch,
                                            logic [SAMPLE_W-1:0] a, logic [SAMPLE_W-1:0] b,
                                            logic [SAMPLE_W-1:0] c, logic [SAMPLE_W-1:0] d);
        t_result             res;
        logic [SUM_W-1:0]    sum;
        logic [SAMPLE_W-1:0] avg;
        logic [FILT_W-1:0]   target;
        logic [FILT_W-1:0]   next_f;
        logic [FILT_W-1:0]   gap;
        logic [GAIN_W-1:0]   g;
        longint              diff;
        longint              moved;
        res = '0;
        if (ch >= CHANNELS) begin
            return res;
        end
        if (kind == REQ_SAMPLE) begin
            sum    = SUM_W'(a) + SUM_W'(b) + SUM_W'(c) + SUM_W'(d);
            avg    = sum[SUM_W-1:2];
            target = {avg, {FRAC_W{1'b0}}};
            avg_mem[ch] = avg;
            if (!primed[ch]) begin
                primed[ch]   = 1'b1;
                filt_mem[ch] = target;
                held_mem[ch] = target;
            end else begin
                g     = (gain_reg > GAIN_ONE) ? GAIN_ONE : gain_reg;
                diff  = longint'(target) - longint'(filt_mem[ch]);
                // arithmetic shift gives floor for a falling input
                moved = longint'(filt_mem[ch]) + ((diff * longint'(g)) >>> FRAC_W);
                if (moved < 0) begin
                    moved = 0;
                end
                if (moved > longint'({FILT_W{1'b1}})) begin
                    moved = longint'({FILT_W{1'b1}});
                end
                next_f = FILT_W'(moved);
                gap    = (next_f >= held_mem[ch]) ? next_f - held_mem[ch]
                                                  : held_mem[ch] - next_f;
                filt_mem[ch] = next_f;
                if (gap >= thresh_reg) begin
                    held_mem[ch]     = next_f;
                    held_flag[ch]    = 1'b1;
                    res.change_flag  = 1'b1;
                    res.change_value = next_f;
                end
            end
        end else if (held_flag[ch]) begin
            held_flag[ch]    = 1'b0;
            res.change_flag  = 1'b1;
            res.change_value = held_mem[ch];
        end
        res.raw_average    = avg_mem[ch];
        res.filtered_value = filt_mem[ch];
        return res;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                avg_mem[i]   = '0;
                filt_mem[i]  = '0;
                held_mem[i]  = '0;
                held_flag[i] = 1'b0;
                primed[i]    = 1'b0;
            end
            gain_reg       = GAIN_RESET;
            thresh_reg     = THRESH_RESET;
            mismatch_count = 0;
            expected_results.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[CFG_ADDR_W-1:2]))
                    REG_GAIN:   gain_reg   = i_pwdata[GAIN_W-1:0];
                    REG_THRESH: thresh_reg = i_pwdata[THRESH_W-1:0];
                    default: ;
                endcase
            end
            if (i_rsp_mon.valid && i_rsp_mon.ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transaction with nothing expected");
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("raw_average", 32'(want.raw_average), 32'(i_rsp_mon.raw_average));
                    check_field("filtered_value", 32'(want.filtered_value),
                                32'(i_rsp_mon.filtered_value));
                    check_field("change_flag", 32'(want.change_flag), 32'(i_rsp_mon.change_flag));
                    check_field("change_value", 32'(want.change_value),
                                32'(i_rsp_mon.change_value));
                end
            end
            if (i_req_mon.valid && i_req_mon.ready) begin
                expected_results.push_back(knob_update(t_req'(i_req_mon.req_type),
                    i_req_mon.channel, i_req_mon.sample_a, i_req_mon.sample_b,
                    i_req_mon.sample_c, i_req_mon.sample_d));
            end
        end
        o_mismatches <= mismatch_count;
        o_in_flight  <= expected_results.size();
    end

endmodule

// File: bench/knob_smoothing_change_detector_top_test.sv
// knob_smoothing_change_detector_top_test: stimulus, clock, reset and verdict
// depends on kscd_pkg, the interfaces, the rtl top and kscd_knob_checker
module knob_smoothing_change_detector_top_test import kscd_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHANNELS       = 8;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 66;
    localparam int DRAIN_CYCLES   = 8;     // a result passes the queue, the store read and the result register
    localparam int WATCHDOG_LIMIT = 1000;  // far above the longest quiet spell of a good run

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int   mismatches;
    int   in_flight;
    int   quiet_cycles = 0;
    logic calm = 1'b0;  // final stretch: no idling on either side

    // rough knob position per channel, samples scatter around it
    int knob_pos [CHANNELS];

    kscd_req_if req_bus ();
    kscd_rsp_if rsp_bus ();

    knob_smoothing_change_detector_top #(
        .CHANNELS (CHANNELS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    kscd_knob_checker #(
        .CHANNELS (CHANNELS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_mon    (req_bus),
        .i_rsp_mon    (rsp_bus),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_mismatches (mismatches),
        .o_in_flight  (in_flight)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // result side back-pressure: random stall bursts until the calm stretch
    initial begin
        rsp_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                rsp_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
            rsp_bus.ready <= 1'b1;
        end
    end

    // watchdog: any transaction or register access counts as progress
    always @(posedge i_clk) begin
        if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) || psel) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // present one request and hold it until the block takes the transaction
    task automatic send_req(t_req kind, logic [CHAN_W-1:0] ch,
                            logic [SAMPLE_W-1:0] a, logic [SAMPLE_W-1:0] b,
                            logic [SAMPLE_W-1:0] c, logic [SAMPLE_W-1:0] d);
        req_bus.valid    <= 1'b1;
        req_bus.req_type <= kind;
        req_bus.channel  <= ch;
        req_bus.sample_a <= a;
        req_bus.sample_b <= b;
        req_bus.sample_c <= c;
        req_bus.sample_d <= d;
        do @(posedge i_clk); while (!req_bus.ready);
        // sender gap; otherwise valid stays high into the next request
        if (!calm && $urandom_range(0, 4) == 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    // wait until every expected result has come back
    task automatic wait_drained();
        do @(posedge i_clk); while (in_flight != 0);
    endtask

    // setup then access; psel stays up between back to back writes
    task automatic cfg_write(t_reg_idx idx, logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    // both registers, with junk in the unused upper bits to exercise masking
    task automatic set_config(logic [GAIN_W-1:0] gain, logic [THRESH_W-1:0] thresh);
        cfg_write(REG_GAIN, {(APB_DATA_W - GAIN_W)'($urandom), gain});
        cfg_write(REG_THRESH, {(APB_DATA_W - THRESH_W)'($urandom), thresh});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [SAMPLE_W-1:0] clamp_sample(int v);
        if (v < 0) begin
            return '0;
        end
        if (v > 4095) begin
            return '1;
        end
        return SAMPLE_W'(v);
    endfunction

    // mostly samples near the knob position; some consumes, wild samples and bad channels
    task automatic random_item();
        t_req                kind;
        logic [CHAN_W-1:0]   ch;
        logic [SAMPLE_W-1:0] s [4];
        int                  slot;
        kind = ($urandom_range(0, 3) == 0) ? REQ_CONSUME : REQ_SAMPLE;
        if ($urandom_range(0, 9) == 0) begin
            ch = CHAN_W'($urandom_range(CHANNELS, 255));
        end else begin
            ch = CHAN_W'($urandom_range(0, CHANNELS - 1));
        end
        slot = ch % CHANNELS;
        if ($urandom_range(0, 7) == 0) begin
            knob_pos[slot] = $urandom_range(0, 4095);
        end else begin
            knob_pos[slot] = int'(clamp_sample(knob_pos[slot]
                                               + int'($urandom_range(0, 400)) - 200));
        end
        for (int k = 0; k < 4; k++) begin
            if ($urandom_range(0, 5) == 0) begin
                s[k] = SAMPLE_W'($urandom);
            end else begin
                s[k] = clamp_sample(knob_pos[slot] + int'($urandom_range(0, 16)) - 8);
            end
        end
        send_req(kind, ch, s[0], s[1], s[2], s[3]);
    endtask

    initial begin : stimulus
        logic [GAIN_W-1:0]   phase_gain   [PHASES];
        logic [THRESH_W-1:0] phase_thresh [PHASES];

        i_rst_n          <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        req_bus.valid    <= 1'b0;
        req_bus.req_type <= REQ_SAMPLE;
        req_bus.channel  <= '0;
        req_bus.sample_a <= '0;
        req_bus.sample_b <= '0;
        req_bus.sample_c <= '0;
        req_bus.sample_d <= '0;
        for (int i = 0; i < CHANNELS; i++) begin
            knob_pos[i] = $urandom_range(0, 4095);
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, reset configuration
        send_req(REQ_SAMPLE,  8'd8,   12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF); // just past the last channel
        send_req(REQ_CONSUME, 8'd255, 12'hFFF, 12'h000, 12'hFFF, 12'h000); // top channel index
        send_req(REQ_CONSUME, 8'd0,   12'h000, 12'h000, 12'h000, 12'h000); // consume, never primed
        send_req(REQ_SAMPLE,  8'd0,   12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF); // prime at full scale
        send_req(REQ_CONSUME, 8'd0,   12'h000, 12'h000, 12'h000, 12'h000); // primed, nothing latched
        send_req(REQ_SAMPLE,  8'd0,   12'h000, 12'h000, 12'h000, 12'h000); // big fall, floor of negative step
        send_req(REQ_CONSUME, 8'd0,   12'h000, 12'h000, 12'h000, 12'h000); // returns the latch
        send_req(REQ_CONSUME, 8'd0,   12'h000, 12'h000, 12'h000, 12'h000); // already cleared
        send_req(REQ_SAMPLE,  8'd1,   12'h000, 12'h000, 12'h000, 12'h000); // prime at zero
        send_req(REQ_SAMPLE,  8'd1,   12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF); // big rise
        send_req(REQ_SAMPLE,  8'd1,   12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF); // latch again before consume
        send_req(REQ_SAMPLE,  8'd2,   12'hFFF, 12'hFFF, 12'hFFF, 12'hFFE); // average truncates down
        send_req(REQ_SAMPLE,  8'd2,   12'hFFE, 12'hFFE, 12'hFFE, 12'hFFF); // same average, no movement
        send_req(REQ_SAMPLE,  8'd2,   12'hFFE, 12'hFFF, 12'hFFE, 12'hFFF);
        send_req(REQ_SAMPLE,  8'd7,   12'd1,   12'd2,   12'd3,   12'd5);   // last channel, tiny values
        send_req(REQ_SAMPLE,  8'd7,   12'd10,  12'd10,  12'd10,  12'd10);  // below threshold
        send_req(REQ_CONSUME, 8'd7,   12'hAAA, 12'h555, 12'hAAA, 12'h555); // nothing pending
        send_req(REQ_CONSUME, 8'd1,   12'h555, 12'hAAA, 12'h555, 12'hAAA); // newest latch wins
        send_req(REQ_SAMPLE,  8'd3,   12'hAAA, 12'h555, 12'hAAA, 12'h555);
        send_req(REQ_SAMPLE,  8'd3,   12'h555, 12'hAAA, 12'h555, 12'hAAA);
        req_bus.valid <= 1'b0;

        // gain: full jump, frozen, above one (saturates), smallest step, random, mid, reset value
        // threshold: zero latches every time, maximum never latches, then assorted
        phase_gain   = '{9'd256, 9'd0, 9'd511, 9'd1, 9'd0, 9'd0, 9'd128, GAIN_RESET};
        phase_thresh = '{20'd0, 20'hFFFFF, 20'd0, 20'd1, 20'd0, 20'd0, 20'd5000, THRESH_RESET};
        phase_thresh[2] = THRESH_W'($urandom_range(0, 40000));
        for (int p = 4; p < 6; p++) begin
            phase_gain[p]   = GAIN_W'($urandom_range(0, 511));
            phase_thresh[p] = THRESH_W'($urandom_range(0, 40000));
        end

        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            set_config(phase_gain[p], phase_thresh[p]);
            if (p == PHASES - 1) begin
                calm <= 1'b1;
            end
            repeat (PHASE_ITEMS) random_item();
            req_bus.valid <= 1'b0;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && in_flight == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: knob_smoothing_change_detector_top.f
rtl/kscd_pkg.sv
rtl/kscd_if.sv
rtl/kscd_front.sv
rtl/kscd_queue.sv
rtl/kscd_back.sv
rtl/knob_smoothing_change_detector_top.sv
bench/kscd_knob_checker.sv
bench/knob_smoothing_change_detector_top_test.sv
